FILE: sv/arpr_pkg.sv
// Package with the shared types and constants of the ARP resolver.
package arpr_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] next_hop_ip;
        logic [15:0] datagram_tag;
        logic [47:0] frame_dst_mac;
        logic [15:0] frame_type;
        logic        payload_ok;
        logic [15:0] arp_opcode;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_sender_ip;
        logic [31:0] arp_target_ip;
        logic [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] dst_mac;
        logic [15:0] tag_out;
        logic [31:0] target_ip;
        logic        last;
    } t_out_item;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] KIND_IPV4    = 3'd0;
    localparam logic [2:0] KIND_REQUEST = 3'd1;
    localparam logic [2:0] KIND_REPLY   = 3'd2;
    localparam logic [2:0] KIND_DELIVER = 3'd3;
    localparam logic [2:0] KIND_DROP    = 3'd4;

    localparam logic [1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [1:0] REG_OWN_IP   = 2'd1;
    localparam logic [1:0] REG_CACHE_LT = 2'd2;
    localparam logic [1:0] REG_PEND_LT  = 2'd3;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] AGE_MAX = 17'h1FFFF;
    localparam logic [15:0] CACHE_LT_RESET = 16'd30000;
    localparam logic [15:0] PEND_LT_RESET  = 16'd5000;

    // Aging function used for cache and queue entries: saturating add of the elapsed time.
    function automatic logic [16:0] age_add(input logic [16:0] age, input logic [15:0] dt);
        logic [17:0] s;
        s = {1'b0, age} + {2'b00, dt};
        return s[17] ? AGE_MAX : s[16:0];
    endfunction

endpackage

FILE: sv/arp_resolver_with_pending_queue.sv
// Top level of the ARP resolver with its cache, pending queue and sequencer.
//
// The resolver takes one command (send, received frame or tick) when start is high and
// busy is low, then walks its tables one entry per cycle with one compare and aging
// unit for the cache and one for the queue. A send scans the cache and, on a miss with
// room in the queue, the occupied part of the pending queue before it enqueues; with
// the queue full it is dropped. A received ARP frame scans the cache to learn, writes
// the entry, then walks the occupied part of the queue once, flushing matching tags,
// and then gives the final flushed transfer and the reply, if any. A tick walks the
// cache and the occupied part of the queue. Busy stays high for these sequential table
// walks; an operation code of 3 is taken and ignored without raising busy. Results
// appear at most one per cycle on o_result with o_result_valid for exactly one cycle;
// the receiver must take every transfer, since the block cannot be stalled. A flushed
// transfer is held back until the next one is known so that the last result of a
// command has last set. Configuration writes are taken at any clock edge through
// i_cfg_we, i_cfg_index and i_cfg_data, and should only be made while busy is low.
module arp_resolver_with_pending_queue #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  arpr_pkg::t_in_item   i_item,
    output logic                 o_result_valid,
    output arpr_pkg::t_out_item  o_result,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [47:0]          i_cfg_data
);
    import arpr_pkg::*;

    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int PCW = $clog2(PENDING_ENTRIES + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CSCAN  = 4'd1;  // cache walk (send lookup, learn, or age)
    localparam logic [3:0] S_PSCAN  = 4'd2;  // queue walk for send duplicate check
    localparam logic [3:0] S_SENDFIN= 4'd3;
    localparam logic [3:0] S_LEARN  = 4'd4;
    localparam logic [3:0] S_FLUSH  = 4'd5;  // queue walk, copy-down compaction
    localparam logic [3:0] S_REPLY  = 4'd6;

    // Configuration.
    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic [15:0] r_cache_lt, r_pend_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac  <= '0;
            r_own_ip   <= '0;
            r_cache_lt <= CACHE_LT_RESET;
            r_pend_lt  <= PEND_LT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OWN_MAC:  r_own_mac  <= i_cfg_data;
                REG_OWN_IP:   r_own_ip   <= i_cfg_data[31:0];
                REG_CACHE_LT: r_cache_lt <= i_cfg_data[15:0];
                REG_PEND_LT:  r_pend_lt  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Cache storage: valid bits in flip-flops, payload in registers read at the scan index.
    logic [CACHE_ENTRIES-1:0] r_cvalid;
    logic [31:0] r_cip  [CACHE_ENTRIES];
    logic [47:0] r_cmac [CACHE_ENTRIES];
    logic [16:0] r_cage [CACHE_ENTRIES];

    // Pending queue, a compacted prefix in arrival order.
    logic [31:0] r_pip  [PENDING_ENTRIES];
    logic [15:0] r_ptag [PENDING_ENTRIES];
    logic [16:0] r_page [PENDING_ENTRIES];
    logic        r_preq [PENDING_ENTRIES];
    logic [PCW-1:0] r_pcount;

    logic [3:0]     r_state;
    t_in_item       r_item;
    logic [CW-1:0]  r_ci;
    logic [PW-1:0]  r_pi;      // read index of the queue walk
    logic [PCW-1:0] r_pw;      // write index of the compaction
    logic           r_hit;
    logic [CW-1:0]  r_slot;
    logic           r_have_free;
    logic [CW-1:0]  r_free;
    logic [CW-1:0]  r_old;
    logic [16:0]    r_old_age;
    logic           r_req_seen;
    logic           r_reply;
    logic           r_ov;
    t_out_item      r_out;
    logic           r_hold_v;  // a flushed transfer waits in r_hold
    t_out_item      r_hold;

    wire c_last = (r_ci == CW'(CACHE_ENTRIES - 1));
    wire [PCW-1:0] pi_ext = PCW'(r_pi);
    wire p_end = (pi_ext + 1'b1 >= r_pcount);

    assign busy = (r_state != S_IDLE);
    assign o_result_valid = r_ov;
    assign o_result = r_out;

    wire accept = start && !busy;

    // Compare units for the entry under the cache pointer and the entry under the queue pointer.
    wire [31:0] key = (r_item.operation == OP_SEND) ? r_item.next_hop_ip : r_item.arp_sender_ip;
    wire c_match = r_cvalid[r_ci] && (r_cip[r_ci] == key);
    wire p_match = (r_pip[r_pi] == key);
    wire [16:0] c_aged = age_add(r_cage[r_ci], r_item.elapsed_ms);
    wire [16:0] p_aged = age_add(r_page[r_pi], r_item.elapsed_ms);
    wire for_us = (r_item.frame_dst_mac == MAC_BCAST) || (r_item.frame_dst_mac == r_own_mac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cvalid <= '0;
            r_pcount <= '0;
            r_ov     <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) begin
                    r_item <= i_item;
                    r_ci <= '0; r_pi <= '0; r_pw <= '0;
                    r_hit <= 1'b0; r_have_free <= 1'b0;
                    r_old <= '0; r_old_age <= '0; r_req_seen <= 1'b0;
                    r_hold_v <= 1'b0;
                    r_reply <= (i_item.arp_opcode == ARP_OP_REQUEST) &&
                               (i_item.arp_target_ip == r_own_ip);
                    if (i_item.operation == OP_SEND || i_item.operation == OP_TICK)
                        r_state <= S_CSCAN;
                    else if (i_item.operation == OP_RECV)
                        r_state <= S_CSCAN;
                end
                S_CSCAN: begin
                    if (r_item.operation == OP_TICK) begin
                        if (r_cvalid[r_ci]) begin
                            r_cage[r_ci] <= c_aged;
                            if (c_aged > {1'b0, r_cache_lt}) r_cvalid[r_ci] <= 1'b0;
                        end
                        if (c_last) r_state <= (r_pcount != '0) ? S_FLUSH : S_IDLE;
                    end else if (r_item.operation == OP_RECV) begin
                        if (!for_us || !r_item.payload_ok ||
                            (r_item.frame_type != ETH_IPV4 && r_item.frame_type != ETH_ARP)) begin
                            r_state <= S_IDLE;
                        end else if (r_item.frame_type == ETH_IPV4) begin
                            r_ov <= 1'b1;
                            r_out <= '{kind: KIND_DELIVER, dst_mac: '0,
                                       tag_out: r_item.datagram_tag, target_ip: '0, last: 1'b1};
                            r_state <= S_IDLE;
                        end else begin
                            if (c_match && !r_hit) begin r_hit <= 1'b1; r_slot <= r_ci; end
                            if (!r_cvalid[r_ci] && !r_have_free) begin
                                r_have_free <= 1'b1; r_free <= r_ci;
                            end
                            if (r_cvalid[r_ci] && (r_ci == '0 || r_cage[r_ci] > r_old_age)) begin
                                r_old <= r_ci; r_old_age <= r_cage[r_ci];
                            end
                            if (c_last) r_state <= S_LEARN;
                        end
                    end else begin
                        if (c_match) begin
                            r_ov <= 1'b1;
                            r_out <= '{kind: KIND_IPV4, dst_mac: r_cmac[r_ci],
                                       tag_out: r_item.datagram_tag, target_ip: '0, last: 1'b1};
                            r_state <= S_IDLE;
                        end else if (c_last) begin
                            if (r_pcount == PCW'(PENDING_ENTRIES)) begin
                                r_ov <= 1'b1;
                                r_out <= '{kind: KIND_DROP, dst_mac: '0,
                                    tag_out: r_item.datagram_tag, target_ip: '0, last: 1'b1};
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= (r_pcount != '0) ? S_PSCAN : S_SENDFIN;
                            end
                        end
                    end
                    r_ci <= r_ci + 1'b1;
                end
                S_PSCAN: begin
                    if (p_match && r_preq[r_pi]) r_req_seen <= 1'b1;
                    r_pi <= r_pi + 1'b1;
                    if (p_end) r_state <= S_SENDFIN;
                end
                S_SENDFIN: begin
                    r_pip[r_pcount[PW-1:0]]  <= r_item.next_hop_ip;
                    r_ptag[r_pcount[PW-1:0]] <= r_item.datagram_tag;
                    r_page[r_pcount[PW-1:0]] <= '0;
                    r_preq[r_pcount[PW-1:0]] <= !r_req_seen;
                    r_pcount <= r_pcount + 1'b1;
                    if (!r_req_seen) begin
                        r_ov <= 1'b1;
                        r_out <= '{kind: KIND_REQUEST, dst_mac: MAC_BCAST, tag_out: '0,
                                   target_ip: r_item.next_hop_ip, last: 1'b1};
                    end
                    r_state <= S_IDLE;
                end
                S_LEARN: begin
                    r_cvalid[r_hit ? r_slot : (r_have_free ? r_free : r_old)] <= 1'b1;
                    r_cip [r_hit ? r_slot : (r_have_free ? r_free : r_old)] <= r_item.arp_sender_ip;
                    r_cmac[r_hit ? r_slot : (r_have_free ? r_free : r_old)] <= r_item.arp_sender_mac;
                    r_cage[r_hit ? r_slot : (r_have_free ? r_free : r_old)] <= '0;
                    r_state <= (r_pcount != '0) ? S_FLUSH : S_REPLY;
                end
                S_FLUSH: begin
                    // Walk the queue, keeping entries by copying them down to the write index.
                    if (r_item.operation == OP_TICK) begin
                        if (p_aged <= {1'b0, r_pend_lt}) begin
                            r_pip[r_pw[PW-1:0]]  <= r_pip[r_pi];
                            r_ptag[r_pw[PW-1:0]] <= r_ptag[r_pi];
                            r_page[r_pw[PW-1:0]] <= p_aged;
                            r_preq[r_pw[PW-1:0]] <= r_preq[r_pi];
                            r_pw <= r_pw + 1'b1;
                        end
                        if (p_end) begin
                            r_pcount <= r_pw + PCW'(p_aged <= {1'b0, r_pend_lt});
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (p_match) begin
                            // The previous flushed transfer goes out now that it is known
                            // not to be the last one; the new one waits in its place.
                            if (r_hold_v) begin
                                r_ov <= 1'b1;
                                r_out <= r_hold;
                            end
                            r_hold_v <= 1'b1;
                            r_hold <= '{kind: KIND_IPV4, dst_mac: r_item.arp_sender_mac,
                                        tag_out: r_ptag[r_pi], target_ip: '0, last: 1'b0};
                        end else begin
                            r_pip[r_pw[PW-1:0]]  <= r_pip[r_pi];
                            r_ptag[r_pw[PW-1:0]] <= r_ptag[r_pi];
                            r_page[r_pw[PW-1:0]] <= r_page[r_pi];
                            r_preq[r_pw[PW-1:0]] <= r_preq[r_pi];
                            r_pw <= r_pw + 1'b1;
                        end
                        if (p_end) begin
                            r_pcount <= r_pw + PCW'(!p_match);
                            r_state <= S_REPLY;
                        end
                    end
                    r_pi <= r_pi + 1'b1;
                end
                S_REPLY: begin
                    if (r_hold_v) begin
                        // Final flushed transfer; a reply, if any, follows next cycle.
                        r_ov <= 1'b1;
                        r_out <= '{kind: KIND_IPV4, dst_mac: r_hold.dst_mac,
                                   tag_out: r_hold.tag_out, target_ip: '0, last: !r_reply};
                        r_hold_v <= 1'b0;
                        r_state <= r_reply ? S_REPLY : S_IDLE;
                    end else begin
                        if (r_reply) begin
                            r_ov <= 1'b1;
                            r_out <= '{kind: KIND_REPLY, dst_mac: r_item.arp_sender_mac,
                                       tag_out: '0, target_ip: r_item.arp_sender_ip,
                                       last: 1'b1};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The queue never holds more entries than it has slots.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= PCW'(PENDING_ENTRIES)) else $error("queue count overflow");
    // A valid command is only taken from idle, so busy rises after a transfer.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.operation == OP_SEND || i_item.operation == OP_RECV ||
                   i_item.operation == OP_TICK) |=> busy) else $error("command not taken");
    // A result is only produced while a command is in progress.
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy)) else $error("stray result");

endmodule
